/* rtl/fpa_pkg.sv */
package fpa_pkg;

    localparam int WordBits = 32;
    localparam int FracBits = 8;
    localparam int KindBits = 4;
    // Dividend magnitude (|a| << FracBits) width
    localparam int DivBits  = WordBits + FracBits;

    typedef enum logic [KindBits-1:0] {
        KIND_ADD      = 4'd0,
        KIND_SUB      = 4'd1,
        KIND_MUL      = 4'd2,
        KIND_DIV      = 4'd3,
        KIND_MIN      = 4'd4,
        KIND_MAX      = 4'd5,
        KIND_INC      = 4'd6,
        KIND_DEC      = 4'd7,
        KIND_FROM_INT = 4'd8,
        KIND_TO_INT   = 4'd9
    } kind_t;

    typedef struct packed {
        logic [KindBits-1:0]        kind;
        logic signed [WordBits-1:0] operand_a;
        logic signed [WordBits-1:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [WordBits-1:0] result;
        logic                       less;
        logic                       equal;
        logic                       greater;
        logic                       overflow;
        logic                       div_by_zero;
    } out_item_t;

    // Per-item control carried alongside the arithmetic through the pipe
    typedef struct packed {
        logic [KindBits-1:0]        kind;
        logic                       neg;
        logic                       less;
        logic                       equal;
        logic                       greater;
        logic                       div_by_zero;
        logic signed [WordBits-1:0] simple;
        logic                       simple_ovf;
    } ctl_t;

endpackage

/* rtl/fpa_stream_if.sv */
interface fpa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/fpa_div_step.sv */
// One restoring division step; each divider stage has its own instance.
module fpa_div_step (
    input  logic [fpa_pkg::DivBits:0]   rem_in,
    input  logic [fpa_pkg::DivBits:0]   quo_in,
    input  logic [fpa_pkg::DivBits:0]   den,
    input  logic                        num_bit,
    output logic [fpa_pkg::DivBits:0]   rem_out,
    output logic [fpa_pkg::DivBits:0]   quo_out
);
    logic [fpa_pkg::DivBits+1:0] trial;

    always_comb
    begin
        trial = {rem_in, num_bit};
        if (trial >= {1'b0, den})
        begin
            rem_out = (fpa_pkg::DivBits+1)'(trial - {1'b0, den});
            quo_out = {quo_in[fpa_pkg::DivBits-1:0], 1'b1};
        end
        else
        begin
            rem_out = trial[fpa_pkg::DivBits:0];
            quo_out = {quo_in[fpa_pkg::DivBits-1:0], 1'b0};
        end
    end
endmodule

/* rtl/fixed_point_q24_8_alu.sv */
// Channel  Dir  Payload
// in       in   kind, operand_a, operand_b
// out      out  result, less, equal, greater, overflow, div_by_zero
//
// One item per cycle while the output is not stalled. The pipeline holds front
// decode, multiplier, 41 divider stages with one quotient bit each, and
// rounding/saturation. Reset clears all stage valid bits.
// A stall holds every stage; nothing is dropped or repeated.
module fixed_point_q24_8_alu (
    input  logic clk,
    input  logic rst_n,
    fpa_stream_if.sink   in,
    fpa_stream_if.source out
);
    localparam int W  = fpa_pkg::WordBits;
    localparam int F  = fpa_pkg::FracBits;
    localparam int D  = fpa_pkg::DivBits;
    // Quotient bits: dividend has D+1 bits (2*|a|<<F + |b|)
    localparam int QB = D + 1;
    localparam int Stages = QB + 3;

    logic [Stages-1:0] vld_reg;
    logic              adv;

    assign adv = !vld_reg[Stages-1] || out.ready;
    assign in.ready = adv;

    // Stage 0: decode
    fpa_pkg::ctl_t     c0_reg;
    logic [W-1:0]      ma0_reg, mb0_reg;
    logic [D:0]        num0_reg;
    logic signed [W-1:0] a_in, b_in;
    logic [W-1:0]      ma_c, mb_c;
    logic signed [W+1:0] sum_c;
    fpa_pkg::ctl_t     c_c;

    assign a_in = in.payload.operand_a;
    assign b_in = in.payload.operand_b;
    assign ma_c = a_in[W-1] ? W'(-a_in) : W'(a_in);
    assign mb_c = b_in[W-1] ? W'(-b_in) : W'(b_in);

    always_comb
    begin
        c_c = '0;
        sum_c = '0;
        c_c.kind = in.payload.kind;
        c_c.less = a_in < b_in;
        c_c.equal = a_in == b_in;
        c_c.greater = a_in > b_in;
        c_c.neg = a_in[W-1] ^ b_in[W-1];
        case (in.payload.kind)
            fpa_pkg::KIND_ADD:  sum_c = (W+2)'(a_in) + (W+2)'(b_in);
            fpa_pkg::KIND_SUB:  sum_c = (W+2)'(a_in) - (W+2)'(b_in);
            fpa_pkg::KIND_INC:  sum_c = (W+2)'(a_in) + (W+2)'(1);
            fpa_pkg::KIND_DEC:  sum_c = (W+2)'(a_in) - (W+2)'(1);
            default:            sum_c = '0;
        endcase
        case (in.payload.kind)
            fpa_pkg::KIND_ADD, fpa_pkg::KIND_SUB, fpa_pkg::KIND_INC, fpa_pkg::KIND_DEC:
            begin
                if (sum_c > (W+2)'($signed({1'b0, {(W-1){1'b1}}})))
                begin
                    c_c.simple = {1'b0, {(W-1){1'b1}}};
                    c_c.simple_ovf = 1'b1;
                end
                else if (sum_c < -(W+2)'($signed({1'b0, 1'b1, {(W-1){1'b0}}})))
                begin
                    c_c.simple = {1'b1, {(W-1){1'b0}}};
                    c_c.simple_ovf = 1'b1;
                end
                else
                    c_c.simple = sum_c[W-1:0];
            end
            fpa_pkg::KIND_MIN: c_c.simple = (a_in < b_in) ? a_in : b_in;
            fpa_pkg::KIND_MAX: c_c.simple = (a_in > b_in) ? a_in : b_in;
            fpa_pkg::KIND_FROM_INT:
            begin
                if (a_in[W-1:W-1-F] != {(F+1){a_in[W-1]}})
                begin
                    c_c.simple = a_in[W-1] ? {1'b1, {(W-1){1'b0}}}
                                           : {1'b0, {(W-1){1'b1}}};
                    c_c.simple_ovf = 1'b1;
                end
                else
                    c_c.simple = {a_in[W-1-F:0], {F{1'b0}}};
            end
            fpa_pkg::KIND_TO_INT: c_c.simple = a_in >>> F;
            fpa_pkg::KIND_DIV:    c_c.div_by_zero = (b_in == '0);
            default:              c_c.simple = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Stages-2:0], in.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg   <= c_c;
            ma0_reg  <= ma_c;
            mb0_reg  <= mb_c;
            num0_reg <= {ma_c, {(F+1){1'b0}}} + (D+1)'(mb_c);
        end
    end

    // Stage 1: multiply, start divider
    logic [2*W-1:0]    prod1_reg;
    logic [D:0]        rem_reg [QB+1];
    logic [D:0]        quo_reg [QB+1];
    logic [D:0]        num_reg [QB+1];
    logic [D:0]        den_reg [QB+1];
    fpa_pkg::ctl_t     ctl_reg [QB+1];
    logic [2*W-1:0]    prod_reg [QB+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= '0;
            quo_reg[0]  <= '0;
            num_reg[0]  <= num0_reg;
            den_reg[0]  <= (D+1)'({mb0_reg, 1'b0});
            ctl_reg[0]  <= c0_reg;
            prod_reg[0] <= ma0_reg * mb0_reg;
        end
    end

    // Stages 2..QB+1: one quotient bit each
    genvar g;
    generate
        for (g = 0; g < QB; g++)
        begin : g_div
            logic [D:0] r_n, q_n;
            fpa_div_step u_step (
                .rem_in  (rem_reg[g]),
                .quo_in  (quo_reg[g]),
                .den     (den_reg[g]),
                .num_bit (num_reg[g][D-g]),
                .rem_out (r_n),
                .quo_out (q_n)
            );
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[g+1]  <= r_n;
                    quo_reg[g+1]  <= q_n;
                    num_reg[g+1]  <= num_reg[g];
                    den_reg[g+1]  <= den_reg[g];
                    ctl_reg[g+1]  <= ctl_reg[g];
                    prod_reg[g+1] <= prod_reg[g];
                end
            end
        end
    endgenerate
    assign prod1_reg = prod_reg[QB];

    // Final stage: round, saturate, select
    fpa_pkg::out_item_t out_reg, out_next;
    fpa_pkg::ctl_t      cf;
    logic [2*W-1:0]     mq;
    logic [2*W-1:0]     mag;
    logic               sat;

    always_comb
    begin
        cf = ctl_reg[QB];
        mq = (prod1_reg + (2*W)'(1 << (F-1))) >> F;
        mag = '0;
        case (cf.kind)
            fpa_pkg::KIND_MUL: mag = mq;
            fpa_pkg::KIND_DIV: mag = (2*W)'(quo_reg[QB]);
            default:           mag = '0;
        endcase
        out_next = '0;
        out_next.less = cf.less;
        out_next.equal = cf.equal;
        out_next.greater = cf.greater;
        sat = 1'b0;
        if (cf.kind == fpa_pkg::KIND_MUL ||
            (cf.kind == fpa_pkg::KIND_DIV && !cf.div_by_zero))
        begin
            if (cf.neg)
            begin
                if (mag > (2*W)'(1) << (W-1))
                begin
                    sat = 1'b1;
                    out_next.result = {1'b1, {(W-1){1'b0}}};
                end
                else
                    out_next.result = W'(-mag);
            end
            else
            begin
                if (mag > ((2*W)'(1) << (W-1)) - (2*W)'(1))
                begin
                    sat = 1'b1;
                    out_next.result = {1'b0, {(W-1){1'b1}}};
                end
                else
                    out_next.result = mag[W-1:0];
            end
            out_next.overflow = sat;
        end
        else
        begin
            out_next.result = cf.simple;
            out_next.overflow = cf.simple_ovf;
            out_next.div_by_zero = cf.div_by_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out.valid = vld_reg[Stages-1];
    assign out.payload = out_reg;
endmodule

/* rtl/fpa_checker.sv */
module fpa_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic div_by_zero,
    input logic overflow,
    input logic less,
    input logic equal,
    input logic greater
);
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({less, equal, greater}))
        else $error("compare flags not exclusive");
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> !overflow)
        else $error("div by zero with overflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under stall");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
endmodule

bind fixed_point_q24_8_alu fpa_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .div_by_zero(out.payload.div_by_zero), .overflow(out.payload.overflow),
    .less(out.payload.less), .equal(out.payload.equal),
    .greater(out.payload.greater)
);
